// ----- design/scvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvc_pkg
// Types and constants for the sparse constraint violation checker.
// ----------------------------------------------------------------------------
package scvc_pkg;

  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned MAX_COLS    = 64;
  localparam int unsigned MAX_ENTRIES = 1024;

  localparam int unsigned ROW_W  = 6;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned ENT_AW = 10;
  localparam int unsigned ENT_CW = 11;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 31;
  localparam int unsigned QUO_W  = 17;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SET_X = 3'd1;
  localparam logic [2:0] OP_SET_B = 3'd2;
  localparam logic [2:0] OP_RUN   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  // unused codes, accepted and ignored
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam logic [CFG_IW-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IW-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_TOLERANCE = 2'd2;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic signed [31:0] row_product;
    logic [30:0]        violation;
    logic [16:0]        weight;
    logic [30:0]        peak_violation;
    logic               all_feasible;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic signed [31:0] value;
  } entry_t;

endpackage

// ----- design/sparse_constraint_violation_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_constraint_violation_check
// Sparse matrix times vector with per-row violation, weight and feasibility.
// ----------------------------------------------------------------------------
// Load commands (add entry, set x, set bound, clear matrix) may follow back
// to back. A run first clears the accumulators and the duplicate map, then
// walks the stored entries: an entry that counts passes entry memory read,
// operand reads, multiply, accumulate and write back; one outside the rows
// or columns in use stops after the operand reads and a duplicate at the
// multiply. It then gives one result per row, one row after another, each
// weight from the 17-step serial divider. busy is high for the whole run and
// drops in the cycle of the last beat; results are single-cycle beats on
// out_valid and cannot be held off by the receiver.
module sparse_constraint_violation_check
  import scvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_CLR   = 11'b00000000010,
    ST_E_RD  = 11'b00000000100,
    ST_E_CHK = 11'b00000001000,
    ST_E_MUL = 11'b00000010000,
    ST_E_ACC = 11'b00000100000,
    ST_R_RD  = 11'b00001000000,
    ST_R_CAL = 11'b00010000000,
    ST_R_CHK = 11'b00100000000,
    ST_R_DIV = 11'b01000000000,
    ST_R_EMT = 11'b10000000000
  } state_t;

  // memories
  entry_t             ent_mem  [MAX_ENTRIES];
  logic signed [31:0] x_mem    [MAX_COLS];
  logic signed [31:0] bnd_mem  [MAX_ROWS];
  logic signed [31:0] acc_mem  [MAX_ROWS];
  logic [MAX_COLS-1:0] seen_mem [MAX_ROWS];

  entry_t              ent_rd_r;
  logic signed [31:0]  x_rd_r, bnd_rd_r, acc_rd_r;
  logic [MAX_COLS-1:0] seen_rd_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  row_count_r, col_count_r;
  logic [30:0]       tol_r;
  logic [ENT_CW-1:0] cnt_r, cnt_nxt;
  logic [ENT_CW-1:0] k_r, k_nxt;
  logic [ROW_W-1:0]  i_r, i_nxt;
  logic [ROW_W-1:0]  er_r, er_nxt;
  logic [COL_W-1:0]  ec_r, ec_nxt;
  logic signed [31:0] ev_r, ev_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [30:0]       viol_r, viol_nxt;
  logic [30:0]       maxv_r, maxv_nxt;
  logic              feas_r, feas_nxt;
  logic [50:0]       rem_r, rem_nxt;
  logic [48:0]       dsh_r, dsh_nxt;
  logic [QUO_W-1:0]  q_r, q_nxt;
  logic              qcap_r, qcap_nxt;
  logic [4:0]        step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [CNT_W-1:0]  rows, cols;
  logic [ROW_W-1:0]  acc_addr;
  logic [COL_W-1:0]  x_addr;
  logic              acc_we, seen_we;
  logic signed [31:0] acc_wd;
  logic [MAX_COLS-1:0] seen_wd;
  logic              accept;

  // datapath temporaries
  logic signed [47:0] term_w;
  logic signed [31:0] term_s;
  logic signed [32:0] sum_w;
  logic signed [32:0] diff_w;
  logic signed [33:0] lim_w;
  logic [32:0]        denom_w;
  logic [34:0]        v10_w;
  logic [30:0]        viol_w;
  logic [QUO_W-1:0]   wt_w;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (row_count_r == '0) rows = CNT_W'(1);
    else if (row_count_r > CNT_W'(MAX_ROWS)) rows = CNT_W'(MAX_ROWS);
    else rows = row_count_r;
    if (col_count_r == '0) cols = CNT_W'(1);
    else if (col_count_r > CNT_W'(MAX_COLS)) cols = CNT_W'(MAX_COLS);
    else cols = col_count_r;
  end

  // read address selection
  always_comb begin
    if (state_r == ST_E_CHK) begin
      acc_addr = ent_rd_r.row;
      x_addr   = ent_rd_r.column;
    end else if (state_r == ST_E_MUL || state_r == ST_E_ACC) begin
      acc_addr = er_r;
      x_addr   = ec_r;
    end else begin
      acc_addr = i_r;
      x_addr   = ec_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_rd_r  <= ent_mem[k_r[ENT_AW-1:0]];
    x_rd_r    <= x_mem[x_addr];
    bnd_rd_r  <= bnd_mem[i_r];
    acc_rd_r  <= acc_mem[acc_addr];
    seen_rd_r <= seen_mem[acc_addr];
    if (accept && in_data.opcode == OP_ADD && cnt_r < ENT_CW'(MAX_ENTRIES)) begin
      ent_mem[cnt_r[ENT_AW-1:0]] <= '{row: in_data.row, column: in_data.column,
                                      value: in_data.value};
    end
    if (accept && in_data.opcode == OP_SET_X) begin
      x_mem[in_data.column] <= in_data.value;
    end
    if (accept && in_data.opcode == OP_SET_B) begin
      bnd_mem[in_data.row] <= in_data.value;
    end
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wd;
    end
    if (seen_we) begin
      seen_mem[acc_addr] <= seen_wd;
    end
  end

  always_comb begin
    term_w = 48'(prod_r >>> 16);
    if (term_w > 48'sd2147483647) term_s = 32'sh7fffffff;
    else if (term_w < -48'sd2147483648) term_s = 32'sh80000000;
    else term_s = term_w[31:0];
    sum_w = 33'(acc_rd_r) + 33'(term_s);

    diff_w  = 33'(acc_rd_r) - 33'(bnd_rd_r);
    lim_w   = 34'(bnd_rd_r) + $signed({3'b000, tol_r});
    denom_w = (bnd_rd_r < 0) ? 33'(-34'(bnd_rd_r)) + 33'd1
                             : 33'(bnd_rd_r) + 33'd1;
    if (diff_w <= 0) viol_w = '0;
    else if (diff_w > 33'sd2147483647) viol_w = 31'h7fffffff;
    else viol_w = diff_w[30:0];
    v10_w = (35'(viol_w) << 3) + (35'(viol_w) << 1);
    wt_w  = (qcap_r || q_r > QUO_W'(65536)) ? QUO_W'(65536) : q_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    er_nxt        = er_r;
    ec_nxt        = ec_r;
    ev_nxt        = ev_r;
    prod_nxt      = prod_r;
    viol_nxt      = viol_r;
    maxv_nxt      = maxv_r;
    feas_nxt      = feas_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    qcap_nxt      = qcap_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    acc_we        = 1'b0;
    seen_we       = 1'b0;
    acc_wd        = '0;
    seen_wd       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_ADD: begin
              if (cnt_r < ENT_CW'(MAX_ENTRIES)) cnt_nxt = cnt_r + 1'b1;
            end
            OP_CLEAR: cnt_nxt = '0;
            OP_RUN: begin
              state_nxt = ST_CLR;
              i_nxt     = '0;
              maxv_nxt  = '0;
              feas_nxt  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        // sweep accumulators and duplicate map, i_r as row pointer
        acc_we  = 1'b1;
        seen_we = 1'b1;
        i_nxt   = i_r + 1'b1;
        k_nxt   = '0;
        if (i_r == ROW_W'(MAX_ROWS - 1)) begin
          state_nxt = (cnt_r == '0) ? ST_R_RD : ST_E_RD;
        end
      end
      ST_E_RD: state_nxt = ST_E_CHK;
      ST_E_CHK: begin
        er_nxt = ent_rd_r.row;
        ec_nxt = ent_rd_r.column;
        ev_nxt = ent_rd_r.value;
        if (CNT_W'(ent_rd_r.row) >= rows || CNT_W'(ent_rd_r.column) >= cols) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = (k_r + 1'b1 == cnt_r) ? ST_R_RD : ST_E_RD;
        end else begin
          state_nxt = ST_E_MUL;
        end
      end
      ST_E_MUL: begin
        prod_nxt = ev_r * x_rd_r;
        if (seen_rd_r[ec_r]) begin
          // drop duplicate, only the first one counts
          k_nxt     = k_r + 1'b1;
          state_nxt = (k_r + 1'b1 == cnt_r) ? ST_R_RD : ST_E_RD;
        end else begin
          state_nxt = ST_E_ACC;
        end
      end
      ST_E_ACC: begin
        acc_we = 1'b1;
        if (sum_w > 33'sd2147483647) acc_wd = 32'sh7fffffff;
        else if (sum_w < -33'sd2147483648) acc_wd = 32'sh80000000;
        else acc_wd = sum_w[31:0];
        seen_we   = 1'b1;
        seen_wd   = seen_rd_r | (MAX_COLS'(1) << ec_r);
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r + 1'b1 == cnt_r) ? ST_R_RD : ST_E_RD;
      end
      ST_R_RD: state_nxt = ST_R_CAL;
      ST_R_CAL: begin
        viol_nxt = viol_w;
        if (viol_w > maxv_r) maxv_nxt = viol_w;
        if (34'(acc_rd_r) > lim_w) feas_nxt = 1'b0;
        rem_nxt  = {v10_w, 16'd0};
        dsh_nxt  = {denom_w, 16'd0};
        q_nxt    = '0;
        out_nxt.row_index   = i_r;
        out_nxt.row_product = acc_rd_r;
        state_nxt = ST_R_CHK;
      end
      ST_R_CHK: begin
        qcap_nxt  = (rem_r >= {1'b0, dsh_r, 1'b0});
        step_nxt  = 5'(QUO_W - 1);
        state_nxt = ST_R_DIV;
      end
      ST_R_DIV: begin
        if (rem_r >= 51'(dsh_r)) begin
          rem_nxt = rem_r - 51'(dsh_r);
          q_nxt   = {q_r[QUO_W-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[QUO_W-2:0], 1'b0};
        end
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) state_nxt = ST_R_EMT;
      end
      ST_R_EMT: begin
        out_valid_nxt     = 1'b1;
        out_nxt.violation = viol_r;
        out_nxt.weight    = wt_w;
        i_nxt             = i_r + 1'b1;
        if (CNT_W'(i_r) == rows - 1'b1) begin
          out_nxt.peak_violation = maxv_r;
          out_nxt.all_feasible   = feas_r;
          out_nxt.last           = 1'b1;
          state_nxt              = ST_IDLE;
        end else begin
          out_nxt.peak_violation = '0;
          out_nxt.all_feasible   = 1'b0;
          out_nxt.last           = 1'b0;
          state_nxt              = ST_R_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
      row_count_r <= CNT_W'(MAX_ROWS);
      col_count_r <= CNT_W'(MAX_COLS);
      tol_r       <= '0;
      maxv_r      <= '0;
      feas_r      <= 1'b1;
      qcap_r      <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
      maxv_r      <= maxv_nxt;
      feas_r      <= feas_nxt;
      qcap_r      <= qcap_nxt;
      step_r      <= step_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_ROW_COUNT: row_count_r <= cfg_wdata[CNT_W-1:0];
          REG_COL_COUNT: col_count_r <= cfg_wdata[CNT_W-1:0];
          REG_TOLERANCE: tol_r       <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    er_r   <= er_nxt;
    ec_r   <= ec_nxt;
    ev_r   <= ev_nxt;
    prod_r <= prod_nxt;
    viol_r <= viol_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ----- design/scvc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvc_checker
// Port-level checks on the run sequencing of the violation checker.
// ----------------------------------------------------------------------------
module scvc_checker
  import scvc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  a_accept_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result beat straight after an accepted command");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> !busy)
    else $error("busy still high on the last beat");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> busy)
    else $error("block idle in the middle of a run");

  a_mid_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |->
      (out_data.peak_violation == '0 && !out_data.all_feasible))
    else $error("summary fields set on a non-last beat");

  a_beat_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in a row");

endmodule

bind sparse_constraint_violation_check scvc_checker u_scvc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);

// ----- verif/tb_sparse_constraint_violation_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_constraint_violation_check
// Self-checking bench for the sparse constraint violation checker. Load and
// run commands are driven through the start/busy port. A scoreboard
// recomputes each run's per-row product, violation, weight and feasibility
// and compares every result beat against them.
// ----------------------------------------------------------------------------
module tb_sparse_constraint_violation_check;
  import scvc_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_data = '0;
  logic              out_valid;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_idx = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  sparse_constraint_violation_check u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow state of the checker
  entry_t        mat_entries [MAX_ENTRIES];
  int unsigned   mat_count;
  logic signed [31:0] x_vec [MAX_COLS];
  logic signed [31:0] bound_vec [MAX_ROWS];
  logic [6:0]    row_cnt_reg;
  logic [6:0]    col_cnt_reg;
  logic [30:0]   tol_reg;

  out_item_t     pending_rows [$];
  int unsigned   fail_count;
  int unsigned   gap_pct;

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Compute every row of a run and queue the resulting beats
  task automatic predict_run();
    int unsigned rows, cols;
    longint      acc [MAX_ROWS];
    bit          seen [MAX_ROWS][MAX_COLS];
    longint      term, prod, bnd, diff, viol, maxv;
    longint unsigned denom, w;
    bit          feasible;
    out_item_t   r;
    rows = (row_cnt_reg == 0) ? 1 : ((row_cnt_reg > MAX_ROWS) ? MAX_ROWS : row_cnt_reg);
    cols = (col_cnt_reg == 0) ? 1 : ((col_cnt_reg > MAX_COLS) ? MAX_COLS : col_cnt_reg);
    maxv = 0;
    feasible = 1'b1;
    for (int i = 0; i < MAX_ROWS; i++) begin
      acc[i] = 0;
      for (int j = 0; j < MAX_COLS; j++) seen[i][j] = 1'b0;
    end
    for (int k = 0; k < mat_count; k++) begin
      entry_t e;
      e = mat_entries[k];
      if (e.row >= rows || e.column >= cols || seen[e.row][e.column]) continue;
      seen[e.row][e.column] = 1'b1;
      term = (longint'(e.value) * longint'(x_vec[e.column])) >>> 16;
      acc[e.row] = sat_s32(acc[e.row] + sat_s32(term));
    end
    for (int i = 0; i < rows; i++) begin
      prod = acc[i];
      bnd = longint'(bound_vec[i]);
      diff = prod - bnd;
      viol = (diff > 0) ? ((diff > 64'sd2147483647) ? 64'sd2147483647 : diff) : 0;
      denom = longint'(bnd < 0 ? -bnd : bnd) + 1;
      w = (longint'(viol) * 655360) / denom;
      if (w > 65536) w = 65536;
      if (viol > maxv) maxv = viol;
      if (prod > bnd + longint'(tol_reg)) feasible = 1'b0;
      r = '0;
      r.row_index = i[5:0];
      r.row_product = prod[31:0];
      r.violation = viol[30:0];
      r.weight = w[16:0];
      if (i == rows - 1) begin
        r.peak_violation = maxv[30:0];
        r.all_feasible = feasible;
        r.last = 1'b1;
      end
      pending_rows.push_back(r);
    end
  endtask

  task automatic apply_command(in_item_t it);
    case (it.opcode)
      OP_ADD: if (mat_count < MAX_ENTRIES) begin
        mat_entries[mat_count] = '{row: it.row, column: it.column, value: it.value};
        mat_count++;
      end
      OP_SET_X: x_vec[it.column] = it.value;
      OP_SET_B: bound_vec[it.row] = it.value;
      OP_CLEAR: mat_count = 0;
      OP_RUN:   predict_run();
      default: ;
    endcase
  endtask

  // Send one command beat, idling at random beforehand
  task automatic send_cmd(logic [2:0] op, logic [5:0] r, logic [5:0] c, logic [31:0] v);
    in_item_t it;
    it = '{opcode: op, row: r, column: c, value: v};
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    apply_command(it);
  endtask

  // Hold off until all results are in and the block has gone idle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait for any run to finish before writing a register
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    @(negedge clk);
    start <= 1'b0;
    while (busy) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROW_COUNT: row_cnt_reg = d[6:0];
      REG_COL_COUNT: col_cnt_reg = d[6:0];
      REG_TOLERANCE: tol_reg = d[30:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      3: return $urandom_range(0, 2) - 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report(string name, longint e, longint a);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        out_item_t e;
        e = pending_rows.pop_front();
        if (out_data.row_index !== e.row_index)
          report("row_index", longint'(e.row_index), longint'(out_data.row_index));
        if (out_data.row_product !== e.row_product)
          report("row_product", longint'(e.row_product), longint'(out_data.row_product));
        if (out_data.violation !== e.violation)
          report("violation", longint'(e.violation), longint'(out_data.violation));
        if (out_data.weight !== e.weight)
          report("weight", longint'(e.weight), longint'(out_data.weight));
        if (out_data.peak_violation !== e.peak_violation)
          report("peak_violation", longint'(e.peak_violation),
                 longint'(out_data.peak_violation));
        if (out_data.all_feasible !== e.all_feasible)
          report("all_feasible", longint'(e.all_feasible), longint'(out_data.all_feasible));
        if (out_data.last !== e.last)
          report("last", longint'(e.last), longint'(out_data.last));
      end
    end
  end

  // Every x and bound is loaded first so that no run reads an unwritten one
  task automatic test_load_vectors();
    for (int i = 0; i < MAX_ROWS; i++) begin
      send_cmd(OP_SET_X, 6'($urandom), i[5:0], rand_q16());
      send_cmd(OP_SET_B, i[5:0], 6'($urandom), rand_q16());
    end
  endtask

  task automatic test_directed_extremes();
    send_cmd(OP_SET_X, 6'd0, 6'd0, 32'h7FFF_FFFF);
    send_cmd(OP_SET_X, 6'd63, 6'd63, 32'h8000_0000);
    send_cmd(OP_SET_B, 6'd0, 6'd0, 32'h8000_0000);
    send_cmd(OP_SET_B, 6'd63, 6'd63, 32'h7FFF_FFFF);
    send_cmd(OP_ADD, 6'd0, 6'd0, 32'h7FFF_FFFF);
    send_cmd(OP_ADD, 6'd0, 6'd0, 32'h0001_0000);
    send_cmd(OP_ADD, 6'd0, 6'd63, 32'h8000_0000);
    send_cmd(OP_ADD, 6'd63, 6'd63, 32'h8000_0000);
    send_cmd(OP_ADD, 6'd63, 6'd0, 32'h8000_0000);
    send_cmd(OP_RSVD5, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_cmd(OP_RSVD6, 6'd0, 6'd0, 32'h0);
    send_cmd(OP_RSVD7, 6'd21, 6'd42, 32'h5555_AAAA);
    send_cmd(OP_RUN, 6'd0, 6'd0, 32'h0);
    drain();
    write_reg(REG_TOLERANCE, 31'h7FFF_FFFF);
    write_reg(REG_ROW_COUNT, 31'd1);
    write_reg(REG_COL_COUNT, 31'd1);
    send_cmd(OP_RUN, 6'd0, 6'd0, 32'h0);
    drain();
    write_reg(REG_ROW_COUNT, 31'd0);
    write_reg(REG_COL_COUNT, 31'h7FFF_FFFF);
    send_cmd(OP_RUN, 6'd63, 6'd63, 32'hFFFF_FFFF);
    drain();
    write_reg(REG_ROW_COUNT, 31'd127);
    write_reg(REG_COL_COUNT, 31'd0);
    write_reg(REG_TOLERANCE, 31'd0);
    send_cmd(OP_CLEAR, 6'd0, 6'd0, 32'h0);
    send_cmd(OP_RUN, 6'd0, 6'd0, 32'h0);
    drain();
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned sent;
    int unsigned n_add;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_ROW_COUNT, ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                             : 31'($urandom_range(1, 12)));
        write_reg(REG_COL_COUNT, ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                             : 31'($urandom_range(1, 12)));
        write_reg(REG_TOLERANCE, $urandom_range(0, 1) ? 31'($urandom)
                                                      : 31'($urandom_range(0, 65536)));
      end
      if ($urandom_range(0, 1)) begin
        send_cmd(OP_CLEAR, 6'($urandom), 6'($urandom), $urandom);
        sent++;
      end
      n_add = $urandom_range(0, 12);
      for (int k = 0; k < n_add; k++) begin
        case ($urandom_range(0, 9))
          0: send_cmd(OP_SET_X, 6'($urandom), 6'($urandom), rand_q16());
          1: send_cmd(OP_SET_B, 6'($urandom), 6'($urandom), rand_q16());
          2: send_cmd(3'($urandom_range(OP_RSVD5, OP_RSVD7)), 6'($urandom), 6'($urandom),
                      $urandom);
          3: send_cmd(OP_ADD, 6'($urandom), 6'($urandom), rand_q16());
          default: send_cmd(OP_ADD, 6'($urandom_range(0, 11)), 6'($urandom_range(0, 11)),
                            rand_q16());
        endcase
        sent++;
      end
      send_cmd(OP_RUN, 6'($urandom), 6'($urandom), $urandom);
      sent++;
      // At random, hold the sender until the whole run has come out
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();
  endtask

  initial begin
    row_cnt_reg = 7'd64;
    col_cnt_reg = 7'd64;
    tol_reg = '0;
    mat_count = 0;
    fail_count = 0;
    gap_pct = 26;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_load_vectors();
    test_directed_extremes();
    test_random(50);
    gap_pct = 77;
    test_random(50);
    gap_pct = 0;
    test_random(50);
    if (fail_count == 0 && pending_rows.size() == 0)
      $display("tb_sparse_constraint_violation_check OK");
    else
      $display("tb_sparse_constraint_violation_check NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_sparse_constraint_violation_check NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
design/scvc_pkg.sv
design/sparse_constraint_violation_check.sv
design/scvc_checker.sv
verif/tb_sparse_constraint_violation_check.sv
